@@ rtl/core/lsom_pkg.sv @@
// ----------------------------------------------------------------------------
// Load switch overcurrent monitor package
// Shared widths, reset values, command and register codes, and the types
// that pass between the front end, the execution unit and the top level.
// ----------------------------------------------------------------------------
package lsom_pkg;

    localparam int ADC_BITS_DEFAULT = 10;

    localparam int CMD_W       = 2;
    localparam int INTERCEPT_W = 17;
    localparam int SLOPE_W     = 16;
    localparam int LIMIT_W     = 15;
    localparam int HOLDOFF_W   = 16;
    localparam int CURRENT_W   = 16;
    localparam int PEAK_W      = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_INTERCEPT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_TX  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_RX  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF   = 3'd4;

    localparam logic [INTERCEPT_W-1:0] INTERCEPT_RESET = 17'd4264;
    localparam logic [SLOPE_W-1:0]     SLOPE_RESET     = 16'd2786;
    localparam logic [LIMIT_W-1:0]     LIMIT_TX_RESET  = 15'd600;
    localparam logic [LIMIT_W-1:0]     LIMIT_RX_RESET  = 15'd50;
    localparam logic [HOLDOFF_W-1:0]   HOLDOFF_RESET   = 16'd500;

    // code * 3300 mV * 1000 scaled to hundredths over the slope
    localparam int                  SCALE_W    = 22;
    localparam logic [SCALE_W-1:0]  CONV_SCALE = 22'd3300000;
    localparam int                  ICPT10_W   = INTERCEPT_W + 4;

    localparam int MAG_W     = 22;
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_MEASURE,
        OP_CHECK,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic transmit;
        logic fault;
    } item_t;

    typedef struct packed {
        logic [INTERCEPT_W-1:0] intercept;
        logic [SLOPE_W-1:0]     slope;
        logic [LIMIT_W-1:0]     limit_tx;
        logic [LIMIT_W-1:0]     limit_rx;
        logic [HOLDOFF_W-1:0]   holdoff;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_ABS,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

@@ rtl/core/lsom_front.sv @@
// ----------------------------------------------------------------------------
// Load switch overcurrent monitor front end
// Accepts input transactions, decodes the command and holds items in a
// two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
module lsom_front
    import lsom_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ADC_BITS-1:0] adc_code,
    input  logic                transmit_mode,
    input  logic                fault_line_n,
    output logic                q_valid,
    output item_t               q_item,
    output logic [ADC_BITS-1:0] q_code,
    input  logic                q_pop
);

    item_t               item_reg [QUEUE_DEPTH];
    logic [ADC_BITS-1:0] code_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    item_t               item_in;

    always_comb
    begin
        item_in.transmit = transmit_mode;
        item_in.fault    = ~fault_line_n;
        case (cmd)
            CMD_TICK:    item_in.op = OP_TICK;
            CMD_MEASURE: item_in.op = OP_MEASURE;
            CMD_CHECK:   item_in.op = OP_CHECK;
            CMD_CLEAR:   item_in.op = OP_CLEAR;
            default:     item_in.op = OP_TICK;
        endcase
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = item_reg[rd_ptr_reg];
    assign q_code   = code_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= item_in;
            code_reg[wr_ptr_reg] <= adc_code;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

@@ rtl/core/lsom_exec.sv @@
// ----------------------------------------------------------------------------
// Load switch overcurrent monitor execution unit
// Converts codes to milliamps with a serial restoring divider, keeps the
// peak, holdoff counter and last current, and holds the result register.
// ----------------------------------------------------------------------------
module lsom_exec
    import lsom_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  item_t                q_item,
    input  logic [ADC_BITS-1:0]  q_code,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CURRENT_W-1:0] current_ma,
    output logic                 overcurrent_flag,
    output logic                 fault_active,
    output logic [PEAK_W-1:0]    peak_current_ma
);

    localparam int PROD_W = ADC_BITS + SCALE_W;
    localparam int DIFF_W = ADC_BITS + SCALE_W + 1;

    state_t               state_reg;
    state_t               state_next;
    item_t                cur_reg;
    logic [ADC_BITS-1:0]  code_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     quo_reg;
    logic [SLOPE_W-1:0]   rem_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [HOLDOFF_W-1:0] since_reg;
    logic [PEAK_W-1:0]    peak_reg;
    logic [CURRENT_W-1:0] last_reg;

    logic                 out_valid_reg;
    logic [CURRENT_W-1:0] current_out_reg;
    logic                 flag_out_reg;
    logic                 fault_out_reg;
    logic [PEAK_W-1:0]    peak_out_reg;

    logic                 out_free;
    logic                 load_mult;
    logic                 load_abs;
    logic                 div_step;
    logic                 fin_fire;

    logic [SLOPE_W-1:0]   slope_eff;
    logic [ICPT10_W-1:0]  icpt10;
    logic [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]    diff_abs;
    logic [DIFF_W-1:0]    diff_shr;
    logic [SLOPE_W:0]     rem_shift;
    logic                 rem_ge;
    logic [CURRENT_W-1:0] conv;
    logic                 is_conv;
    logic [CURRENT_W-1:0] current_next;
    logic [LIMIT_W-1:0]   limit_sel;
    logic                 flag_next;
    logic [HOLDOFF_W-1:0] since_next;
    logic [PEAK_W-1:0]    peak_next;

    assign out_free = !out_valid_reg || out_ready;
    assign is_conv  = (cur_reg.op == OP_MEASURE) || (cur_reg.op == OP_CHECK);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ((q_item.op == OP_MEASURE) || (q_item.op == OP_CHECK))
                                 ? ST_MULT : ST_FIN;
                end
            end
            ST_MULT: state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load_mult = 1'b0;
        load_abs  = 1'b0;
        div_step  = 1'b0;
        fin_fire  = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop     = q_valid;
            ST_MULT: load_mult = 1'b1;
            ST_ABS:  load_abs  = 1'b1;
            ST_DIV:  div_step  = 1'b1;
            ST_FIN:  fin_fire  = out_free;
            default: q_pop     = 1'b0;
        endcase
    end

    // signed difference in units of 2^-ADC_BITS hundredths, then magnitude
    assign slope_eff = (cfg.slope == '0) ? SLOPE_W'(1) : cfg.slope;
    assign icpt10    = (ICPT10_W'(cfg.intercept) << 3) + (ICPT10_W'(cfg.intercept) << 1);
    assign diff      = {1'b0, prod_reg}
                     - {{(DIFF_W - ICPT10_W - ADC_BITS){1'b0}}, icpt10, {ADC_BITS{1'b0}}};
    assign diff_abs  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign diff_shr  = diff_abs >> ADC_BITS;

    assign rem_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, slope_eff});

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg >= MAG_W'(32768))
            begin
                conv = 16'h8000;
            end
            else
            begin
                conv = ~quo_reg[CURRENT_W-1:0] + 1'b1;
            end
        end
        else
        begin
            if (quo_reg > MAG_W'(32767))
            begin
                conv = 16'h7FFF;
            end
            else
            begin
                conv = quo_reg[CURRENT_W-1:0];
            end
        end
    end

    always_comb
    begin
        current_next = is_conv ? conv : last_reg;
        limit_sel    = cur_reg.transmit ? cfg.limit_tx : cfg.limit_rx;
        flag_next    = 1'b0;
        since_next   = since_reg;
        peak_next    = peak_reg;
        case (cur_reg.op)
            OP_TICK:
            begin
                if (since_reg != '1)
                begin
                    since_next = since_reg + 1'b1;
                end
            end
            OP_MEASURE:
            begin
                if ($signed(current_next) > $signed({1'b0, peak_reg}))
                begin
                    peak_next = current_next[PEAK_W-1:0];
                end
            end
            OP_CHECK:
            begin
                if ((($signed(current_next) > $signed({1'b0, limit_sel}))
                     && (since_reg > cfg.holdoff)) || cur_reg.fault)
                begin
                    flag_next  = 1'b1;
                    since_next = '0;
                end
            end
            OP_CLEAR: peak_next = '0;
            default:  peak_next = peak_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            since_reg     <= '0;
            peak_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_abs)
            begin
                cnt_reg <= '0;
            end
            else if (div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (fin_fire)
            begin
                since_reg     <= since_next;
                peak_reg      <= peak_next;
                last_reg      <= current_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg  <= q_item;
            code_reg <= q_code;
        end
        if (load_mult)
        begin
            prod_reg <= PROD_W'(code_reg) * PROD_W'(CONV_SCALE);
        end
        if (load_abs)
        begin
            neg_reg <= diff[DIFF_W-1];
            quo_reg <= diff_shr[MAG_W-1:0];
            rem_reg <= '0;
        end
        else if (div_step)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], rem_ge};
            rem_reg <= rem_ge ? SLOPE_W'(rem_shift - {1'b0, slope_eff})
                              : rem_shift[SLOPE_W-1:0];
        end
        if (fin_fire)
        begin
            current_out_reg <= current_next;
            flag_out_reg    <= flag_next;
            fault_out_reg   <= cur_reg.fault;
            peak_out_reg    <= peak_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign current_ma       = current_out_reg;
    assign overcurrent_flag = flag_out_reg;
    assign fault_active     = fault_out_reg;
    assign peak_current_ma  = peak_out_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider step count out of range");

    a_fault_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && (cur_reg.op == OP_CHECK) && cur_reg.fault) |=> flag_out_reg)
        else $error("fault on check did not raise the flag");

    a_flag_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && (cur_reg.op != OP_CHECK)) |=> !flag_out_reg)
        else $error("flag raised outside a check");

    a_flag_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && flag_next) |=> (since_reg == '0))
        else $error("holdoff counter not restarted by a flag");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |-> out_free)
        else $error("result register overwritten while held");

endmodule

@@ rtl/core/load_switch_overcurrent_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// Load switch overcurrent monitor
// Top level: configuration registers, front end queue and execution unit.
// ----------------------------------------------------------------------------
// Each input transaction gives one result transaction. Tick and clear items
// go from latch straight to write-out; measure and check items pass through
// latch, multiply, magnitude, 22 steps of the restoring divider and write-out,
// using the one-bit-per-cycle divider. A two-entry queue accepts new items while an
// item is in the divider or a result waits. Configuration writes are always
// accepted and are ignored for indexes beyond the register list.
module load_switch_overcurrent_monitor_unit
    import lsom_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [ADC_BITS-1:0]    adc_code,
    input  logic                   transmit_mode,
    input  logic                   fault_line_n,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CURRENT_W-1:0]   current_ma,
    output logic                   overcurrent_flag,
    output logic                   fault_active,
    output logic [PEAK_W-1:0]      peak_current_ma
);

    cfg_t                cfg_reg;
    logic                q_valid;
    item_t               q_item;
    logic [ADC_BITS-1:0] q_code;
    logic                q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.intercept <= INTERCEPT_RESET;
            cfg_reg.slope     <= SLOPE_RESET;
            cfg_reg.limit_tx  <= LIMIT_TX_RESET;
            cfg_reg.limit_rx  <= LIMIT_RX_RESET;
            cfg_reg.holdoff   <= HOLDOFF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INTERCEPT: cfg_reg.intercept <= cfg_data[INTERCEPT_W-1:0];
                REG_SLOPE:     cfg_reg.slope     <= cfg_data[SLOPE_W-1:0];
                REG_LIMIT_TX:  cfg_reg.limit_tx  <= cfg_data[LIMIT_W-1:0];
                REG_LIMIT_RX:  cfg_reg.limit_rx  <= cfg_data[LIMIT_W-1:0];
                REG_HOLDOFF:   cfg_reg.holdoff   <= cfg_data[HOLDOFF_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    lsom_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .adc_code      (adc_code),
        .transmit_mode (transmit_mode),
        .fault_line_n  (fault_line_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_code        (q_code),
        .q_pop         (q_pop)
    );

    lsom_exec #(
        .ADC_BITS (ADC_BITS)
    ) u_exec (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_code           (q_code),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .current_ma       (current_ma),
        .overcurrent_flag (overcurrent_flag),
        .fault_active     (fault_active),
        .peak_current_ma  (peak_current_ma)
    );

endmodule
